FILE: hw/rtl/dtlv_pkg.sv
// Shared types and constants for the discovery TLV block parser.
// Used by the front parser, the result queue, the output stage and the top level.
package dtlv_pkg;

  localparam int unsigned TDATA_W = 144;
  localparam int unsigned TUSER_W = 2;

  localparam logic [3:0] HDR_BYTES     = 4'd12;
  localparam logic [3:0] HDR_SPLIT     = 4'd8;
  localparam logic [3:0] BLK_HDR_BYTES = 4'd4;

  typedef enum logic [1:0] {
    KIND_HEADER     = 2'd0,
    KIND_BLOCK_HDR  = 2'd1,
    KIND_BLOCK_BYTE = 2'd2,
    KIND_FRAME_END  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_TRUNC   = 2'd1,
    STATUS_OVERRUN = 2'd2
  } status_e;

  // One queue entry: an optional header/block/data result and an optional
  // frame end status that follows it. Fields unused by the kind are zero.
  typedef struct packed {
    logic        has_main;
    kind_e       kind;
    logic [15:0] frame_id;
    logic [7:0]  service;
    logic [7:0]  msg_type;
    logic [31:0] xid;
    logic [15:0] delay;
    logic [15:0] data_length;
    logic [7:0]  option;
    logic [7:0]  suboption;
    logic [15:0] block_length;
    logic [7:0]  block_byte;
    logic        has_end;
    status_e     status;
  } entry_t;

endpackage

FILE: hw/rtl/dtlv_front.sv
// Front parser: accepts payload bytes, tracks header and block state, and
// emits one queue entry per byte that produces results. Depends on dtlv_pkg.
module dtlv_front
  import dtlv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       queue_full_i,
  output logic       byte_ready_o,
  output logic       push_o,
  output entry_t     push_data_o
);

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_BLKHDR = 3'd1,
    PH_DATA   = 3'd2,
    PH_PAD    = 3'd3,
    PH_SKIP   = 3'd4
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  hdr_idx_q, hdr_idx_d;
  logic [63:0] hdr_shift_q, hdr_shift_d;
  logic [15:0] region_left_q, region_left_d;
  logic [15:0] block_left_q, block_left_d;
  logic [31:0] blk_shift_q, blk_shift_d;
  logic        block_odd_q, block_odd_d;
  logic        block_err_q, block_err_d;
  logic        accept;
  logic [15:0] blk_len;
  entry_t      ent;

  // A new block starts only if a full block header still fits in the region.
  function automatic phase_e region_next(input logic [15:0] left);
    phase_e ph;
    ph = (left >= {12'd0, BLK_HDR_BYTES}) ? PH_BLKHDR : PH_SKIP;
    return ph;
  endfunction

  assign byte_ready_o = !queue_full_i;
  assign accept       = byte_valid_i && !queue_full_i;

  always_comb begin
    phase_d       = phase_q;
    hdr_idx_d     = hdr_idx_q;
    hdr_shift_d   = hdr_shift_q;
    region_left_d = region_left_q;
    block_left_d  = block_left_q;
    blk_shift_d   = blk_shift_q;
    block_odd_d   = block_odd_q;
    block_err_d   = block_err_q;
    blk_len       = '0;
    ent           = '0;

    if (accept) begin
      case (phase_q)
        PH_HEADER: begin
          if (hdr_idx_q < HDR_SPLIT) begin
            hdr_shift_d = {hdr_shift_q[55:0], data_byte_i};
          end else begin
            blk_shift_d = {blk_shift_q[23:0], data_byte_i};
          end
          hdr_idx_d = hdr_idx_q + 4'd1;
          if (hdr_idx_d == HDR_BYTES) begin
            ent.has_main    = 1'b1;
            ent.kind        = KIND_HEADER;
            ent.frame_id    = hdr_shift_d[63:48];
            ent.service     = hdr_shift_d[47:40];
            ent.msg_type    = hdr_shift_d[39:32];
            ent.xid         = hdr_shift_d[31:0];
            ent.delay       = blk_shift_d[31:16];
            ent.data_length = blk_shift_d[15:0];
            region_left_d   = blk_shift_d[15:0];
            hdr_idx_d       = '0;
            phase_d         = region_next(region_left_d);
          end
        end
        PH_BLKHDR: begin
          blk_shift_d = {blk_shift_q[23:0], data_byte_i};
          blk_len     = blk_shift_d[15:0];
          if (region_left_q != '0) begin
            region_left_d = region_left_q - 16'd1;
          end
          hdr_idx_d = hdr_idx_q + 4'd1;
          if (hdr_idx_d == BLK_HDR_BYTES) begin
            hdr_idx_d = '0;
            if (blk_len > region_left_d) begin
              block_err_d = 1'b1;
              phase_d     = PH_SKIP;
            end else begin
              ent.has_main     = 1'b1;
              ent.kind         = KIND_BLOCK_HDR;
              ent.option       = blk_shift_d[31:24];
              ent.suboption    = blk_shift_d[23:16];
              ent.block_length = blk_len;
              block_left_d     = blk_len;
              block_odd_d      = blk_len[0];
              if (blk_len == '0) begin
                phase_d = region_next(region_left_d);
              end else begin
                phase_d = PH_DATA;
              end
            end
          end
        end
        PH_DATA: begin
          ent.has_main   = 1'b1;
          ent.kind       = KIND_BLOCK_BYTE;
          ent.block_byte = data_byte_i;
          if (block_left_q != '0) begin
            block_left_d = block_left_q - 16'd1;
          end
          if (region_left_q != '0) begin
            region_left_d = region_left_q - 16'd1;
          end
          if (block_left_d == '0) begin
            if (block_odd_q && region_left_d != '0) begin
              phase_d = PH_PAD;
            end else begin
              hdr_idx_d = '0;
              phase_d   = region_next(region_left_d);
            end
          end
        end
        PH_PAD: begin
          if (region_left_q != '0) begin
            region_left_d = region_left_q - 16'd1;
          end
          hdr_idx_d = '0;
          phase_d   = region_next(region_left_d);
        end
        default: begin
          phase_d = PH_SKIP;
          if (region_left_q != '0) begin
            region_left_d = region_left_q - 16'd1;
          end
        end
      endcase

      if (last_byte_i) begin
        ent.has_end = 1'b1;
        // Truncation wins over a latched overrun.
        if (phase_d == PH_HEADER || region_left_d != '0) begin
          ent.status = STATUS_TRUNC;
        end else if (block_err_d) begin
          ent.status = STATUS_OVERRUN;
        end else begin
          ent.status = STATUS_OK;
        end
        phase_d       = PH_HEADER;
        hdr_idx_d     = '0;
        hdr_shift_d   = '0;
        region_left_d = '0;
        block_left_d  = '0;
        blk_shift_d   = '0;
        block_odd_d   = 1'b0;
        block_err_d   = 1'b0;
      end
    end
  end

  assign push_o      = accept && (ent.has_main || ent.has_end);
  assign push_data_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_HEADER;
      hdr_idx_q     <= '0;
      hdr_shift_q   <= '0;
      region_left_q <= '0;
      block_left_q  <= '0;
      blk_shift_q   <= '0;
      block_odd_q   <= 1'b0;
      block_err_q   <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      hdr_idx_q     <= hdr_idx_d;
      hdr_shift_q   <= hdr_shift_d;
      region_left_q <= region_left_d;
      block_left_q  <= block_left_d;
      blk_shift_q   <= blk_shift_d;
      block_odd_q   <= block_odd_d;
      block_err_q   <= block_err_d;
    end
  end

  a_data_within_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> (block_left_q != '0 && block_left_q <= region_left_q))
    else $error("block data count exceeds region count");

  a_blkhdr_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BLKHDR |-> hdr_idx_q < BLK_HDR_BYTES)
    else $error("block header index out of range");

endmodule

FILE: hw/rtl/dtlv_queue.sv
// Small result queue between the front parser and the output stage.
// Register storage with one read port. Depends on dtlv_pkg.
module dtlv_queue
  import dtlv_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output entry_t pop_data_o,
  output logic   empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t        mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic          do_push, do_pop;

  assign full_o     = (count_q == FULL_CNT);
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("queue count above depth");

  a_no_lost_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("entry pushed into a full queue");

endmodule

FILE: hw/rtl/dtlv_back.sv
// Output stage: drains queue entries into a registered result stream,
// sending the main result before the frame end status. Depends on dtlv_pkg.
module dtlv_back
  import dtlv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  entry_t             head_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output logic [TDATA_W-1:0] m_tdata_o,
  output logic [TUSER_W-1:0] m_tuser_o
);

  logic               valid_q, valid_d;
  logic               main_done_q, main_done_d;
  logic [TDATA_W-1:0] tdata_q, tdata_d;
  kind_e              kind_q, kind_d;
  logic               load;

  assign load = !valid_q || m_tready_i;

  always_comb begin
    valid_d     = valid_q;
    main_done_d = main_done_q;
    tdata_d     = tdata_q;
    kind_d      = kind_q;
    pop_o       = 1'b0;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        if (head_i.has_main && !main_done_q) begin
          kind_d  = head_i.kind;
          tdata_d = {6'd0, STATUS_OK, head_i.block_byte, head_i.block_length,
                     head_i.suboption, head_i.option, head_i.data_length,
                     head_i.delay, head_i.xid, head_i.msg_type, head_i.service,
                     head_i.frame_id};
          if (head_i.has_end) begin
            main_done_d = 1'b1;
          end else begin
            pop_o = 1'b1;
          end
        end else begin
          kind_d      = KIND_FRAME_END;
          tdata_d     = {6'd0, head_i.status, 136'd0};
          main_done_d = 1'b0;
          pop_o       = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      main_done_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      main_done_q <= main_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tdata_q <= tdata_d;
    kind_q  <= kind_d;
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = tdata_q;
  assign m_tuser_o  = kind_q;

  a_end_only_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q == KIND_FRAME_END) |-> tdata_q[135:0] == '0)
    else $error("frame end result carries nonzero payload fields");

endmodule

FILE: hw/rtl/discovery_tlv_block_parser.sv
// Discovery TLV block parser, top level. A result is registered in the queue
// and then in the output register after the byte that causes it is accepted.
// Throughput: one byte per cycle while the queue is not full; a final byte that
// also closes a header, block header or data byte yields two results from one
// queue entry, absorbed by the QUEUE_DEPTH-entry queue. Reset returns the parser
// to the header phase and empties the queue and the output register.
module discovery_tlv_block_parser
  import dtlv_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,  // data_byte[7:0]
  input  logic               s_axis_tlast,  // last_byte
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // frame_id[15:0], service[23:16], msg_type[31:24], xid[63:32], delay[79:64],
  // data_length[95:80], option[103:96], suboption[111:104],
  // block_length[127:112], block_byte[135:128], status[137:136], zero[143:138]
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic [TUSER_W-1:0] m_axis_tuser   // kind[1:0]
);

  logic   push, full, pop, empty;
  entry_t push_data, head;

  dtlv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .data_byte_i  (s_axis_tdata),
    .last_byte_i  (s_axis_tlast),
    .queue_full_i (full),
    .byte_ready_o (s_axis_tready),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  dtlv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (head),
    .empty_o     (empty)
  );

  dtlv_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .empty_i    (empty),
    .pop_o      (pop),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser)
  );

endmodule

FILE: bench/discovery_tlv_block_parser_tb.sv
// Self-checking bench for the discovery TLV block parser: byte frames go in
// on the slave stream and parsed results are checked on the master stream.
// Depends on dtlv_pkg and the discovery_tlv_block_parser top level.
module discovery_tlv_block_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dtlv_pkg::*;

  localparam int unsigned RANDOM_BYTES = 570;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned HOLD_AT      = 100;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned TAIL_CYCLES  = 20;

  typedef enum logic [2:0] {
    ST_HEADER,
    ST_BLKHDR,
    ST_DATA,
    ST_PAD,
    ST_SKIP
  } parse_state_e;

  // Layout of m_axis_tdata, highest field first.
  typedef struct packed {
    logic [5:0]  zero;
    logic [1:0]  status;
    logic [7:0]  block_byte;
    logic [15:0] block_length;
    logic [7:0]  suboption;
    logic [7:0]  option;
    logic [15:0] data_length;
    logic [15:0] delay;
    logic [31:0] xid;
    logic [7:0]  msg_type;
    logic [7:0]  service;
    logic [15:0] frame_id;
  } tlv_fields_t;

  typedef struct packed {
    kind_e       kind;
    tlv_fields_t f;
  } tlv_result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       drain;
  } stim_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata = '0;
  logic               s_axis_tlast = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;
  logic [TUSER_W-1:0] m_axis_tuser;

  stim_t       byte_stream[$];
  logic [7:0]  frame_buf[$];
  tlv_result_t pending_results[$];

  // Predictor state.
  parse_state_e ps;
  logic [3:0]   hdr_cnt;
  logic [63:0]  hdr_acc;
  logic [15:0]  region_left;
  logic [15:0]  blk_left;
  logic [31:0]  blk_acc;
  logic         blk_odd;
  logic         blk_err;

  int unsigned errors;
  int unsigned frames_built;
  int unsigned bytes_sent;
  int unsigned results_seen;
  int unsigned input_stalls;
  int unsigned status_seen[3];
  int unsigned send_gap;
  int unsigned recv_wait;
  int unsigned hold_left;
  int unsigned cycle_count;
  logic        sender_burst;
  logic        recv_burst;
  logic        offer_next;
  stim_t       nxt;
  tlv_result_t got;
  tlv_result_t want;

  discovery_tlv_block_parser uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic void clear_parse_state();
    ps          = ST_HEADER;
    hdr_cnt     = '0;
    hdr_acc     = '0;
    region_left = '0;
    blk_left    = '0;
    blk_acc     = '0;
    blk_odd     = 1'b0;
    blk_err     = 1'b0;
  endfunction

  function automatic void enter_region();
    hdr_cnt = '0;
    ps = (region_left >= 16'(BLK_HDR_BYTES)) ? ST_BLKHDR : ST_SKIP;
  endfunction

  // An odd block is followed by one pad byte, but only while the region lasts.
  function automatic void close_block();
    if (blk_odd && region_left > 0) begin
      ps = ST_PAD;
    end else begin
      enter_region();
    end
  endfunction

  task automatic predict_parse(input logic [7:0] b, input logic fin);
    tlv_result_t r;
    logic [15:0] blen;
    case (ps)
      ST_HEADER: begin
        if (hdr_cnt < HDR_SPLIT) begin
          hdr_acc = {hdr_acc[55:0], b};
        end else begin
          blk_acc = {blk_acc[23:0], b};
        end
        hdr_cnt++;
        if (hdr_cnt >= HDR_BYTES) begin
          r               = '0;
          r.kind          = KIND_HEADER;
          r.f.frame_id    = hdr_acc[63:48];
          r.f.service     = hdr_acc[47:40];
          r.f.msg_type    = hdr_acc[39:32];
          r.f.xid         = hdr_acc[31:0];
          r.f.delay       = blk_acc[31:16];
          r.f.data_length = blk_acc[15:0];
          pending_results = {pending_results, r};
          region_left = blk_acc[15:0];
          enter_region();
        end
      end
      ST_BLKHDR: begin
        blk_acc = {blk_acc[23:0], b};
        if (region_left > 0) region_left--;
        hdr_cnt++;
        if (hdr_cnt >= BLK_HDR_BYTES) begin
          hdr_cnt = '0;
          blen    = blk_acc[15:0];
          if (blen > region_left) begin
            // Overrun: latch the error and swallow the rest of the frame.
            blk_err = 1'b1;
            ps      = ST_SKIP;
          end else begin
            r                = '0;
            r.kind           = KIND_BLOCK_HDR;
            r.f.option       = blk_acc[31:24];
            r.f.suboption    = blk_acc[23:16];
            r.f.block_length = blen;
            pending_results  = {pending_results, r};
            blk_left = blen;
            blk_odd  = blen[0];
            if (blen == 0) begin
              close_block();
            end else begin
              ps = ST_DATA;
            end
          end
        end
      end
      ST_DATA: begin
        r               = '0;
        r.kind          = KIND_BLOCK_BYTE;
        r.f.block_byte  = b;
        pending_results = {pending_results, r};
        if (blk_left > 0) blk_left--;
        if (region_left > 0) region_left--;
        if (blk_left == 0) close_block();
      end
      ST_PAD: begin
        if (region_left > 0) region_left--;
        enter_region();
      end
      default: begin
        ps = ST_SKIP;
        if (region_left > 0) region_left--;
      end
    endcase
    if (fin) begin
      r      = '0;
      r.kind = KIND_FRAME_END;
      // Truncation wins over a latched overrun.
      if (ps == ST_HEADER || region_left > 0) begin
        r.f.status = STATUS_TRUNC;
      end else if (blk_err) begin
        r.f.status = STATUS_OVERRUN;
      end else begin
        r.f.status = STATUS_OK;
      end
      pending_results = {pending_results, r};
      clear_parse_state();
    end
  endtask

  // ----------------------------------------------------------------- stimulus

  function automatic void put_random(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
  endfunction

  function automatic void put_block(input logic [7:0] opt, input logic [7:0] sub,
                                    input logic [15:0] len, input int unsigned ndata);
    frame_buf = {frame_buf, opt, sub, len[15:8], len[7:0]};
    put_random(ndata);
  endfunction

  // The header goes in front of whatever region bytes are already buffered.
  function automatic void prepend_header(input logic [15:0] fid, input logic [7:0] svc,
                                         input logic [7:0] typ, input logic [31:0] xid,
                                         input logic [15:0] dly, input logic [15:0] dlen);
    logic [95:0] h;
    h = {fid, svc, typ, xid, dly, dlen};
    for (int i = 0; i < 12; i++) frame_buf.push_front(h[8*i +: 8]);
  endfunction

  function automatic void prepend_random_header(input logic [15:0] dlen);
    prepend_header(16'($urandom), 8'($urandom), 8'($urandom), $urandom, 16'($urandom), dlen);
  endfunction

  // Moves the buffered frame into the send queue, cut short to keep bytes if
  // keep is nonzero, and marks the last byte.
  function automatic void flush_frame(input int unsigned keep, input logic drain);
    stim_t s;
    int unsigned n;
    n = (keep != 0 && keep < frame_buf.size()) ? keep : frame_buf.size();
    for (int unsigned i = 0; i < n; i++) begin
      s.data  = frame_buf[i];
      s.fin   = (i == n - 1);
      s.drain = drain && (i == 0);
      byte_stream = {byte_stream, s};
    end
    frame_buf.delete();
    frames_built++;
  endfunction

  function automatic void put_random_frame(input logic drain);
    int unsigned sel;
    int unsigned nblk;
    int unsigned len;
    int unsigned tail;
    sel = $urandom_range(0, 19);
    if (sel == 0) begin
      put_random($urandom_range(1, 20));
      flush_frame(0, drain);
      return;
    end
    nblk = $urandom_range(0, 3);
    for (int unsigned i = 0; i < nblk; i++) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
      put_block(8'($urandom), 8'($urandom), 16'(len), len);
      if (len % 2 == 1 && (i + 1 < nblk || $urandom_range(0, 1) == 1)) put_random(1);
    end
    if (sel <= 3) begin
      tail = $urandom_range(0, 3);
      len  = ($urandom_range(0, 7) == 0) ? 16'hFFFF : tail + $urandom_range(1, 40);
      put_block(8'($urandom), 8'($urandom), 16'(len), tail);
    end else if ($urandom_range(0, 3) == 0) begin
      put_random($urandom_range(1, 3));
    end
    len = frame_buf.size();
    if ($urandom_range(0, 3) == 0) put_random($urandom_range(1, 3));
    prepend_random_header(16'(len));
    flush_frame(($urandom_range(0, 7) == 0) ? $urandom_range(1, frame_buf.size() - 1) : 0,
                drain);
  endfunction

  initial begin
    int unsigned directed_bytes;
    int unsigned drain_cycles;

    // A lone byte that is also the last one.
    put_random(1);
    flush_frame(0, 1'b0);
    // All-ones header declaring the largest region, ending right after it.
    prepend_header(16'hFFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    flush_frame(0, 1'b0);
    // All-zero header with an empty region.
    prepend_header('0, '0, '0, '0, '0, '0);
    flush_frame(0, 1'b0);
    // Odd block, its pad byte, a short region tail and a byte past the region.
    put_block(8'h01, 8'h02, 16'd1, 1);
    put_random(2);
    prepend_header(16'hFEFE, 8'h05, 8'h00, 32'h1234_5678, 16'h0001, 16'd7);
    put_random(1);
    flush_frame(0, 1'b0);
    // Empty block whose header closes the frame.
    put_block(8'hFF, 8'h00, 16'd0, 0);
    prepend_header(16'hFEFF, 8'h05, 8'h01, 32'h8000_0001, 16'h00FF, 16'd4);
    flush_frame(0, 1'b0);
    // Block of maximum length overrunning the region, then two trailing bytes.
    put_block(8'h00, 8'hFF, 16'hFFFF, 0);
    put_random(2);
    prepend_header(16'hFEFC, 8'h05, 8'h00, 32'h0000_0002, 16'h8000, 16'd4);
    flush_frame(0, 1'b0);
    // Overrun latched but the frame ends inside the region.
    put_block(8'h02, 8'h03, 16'd9, 1);
    prepend_header(16'hFEFD, 8'h06, 8'h01, 32'h0000_0003, 16'h0000, 16'd9);
    flush_frame(0, 1'b0);
    // Final byte is a block data byte.
    put_block(8'h02, 8'h02, 16'd2, 2);
    prepend_header(16'hFEFE, 8'h03, 8'h00, 32'h0000_0004, 16'h0002, 16'd6);
    flush_frame(0, 1'b0);
    // Final byte is the pad byte after an odd block.
    put_block(8'h05, 8'h01, 16'd1, 1);
    put_random(1);
    prepend_header(16'hFEFE, 8'h04, 8'h00, 32'h0000_0005, 16'h0003, 16'd6);
    flush_frame(0, 1'b0);

    directed_bytes = byte_stream.size();
    while (byte_stream.size() < directed_bytes + RANDOM_BYTES) begin
      put_random_frame(frames_built == 20);
    end

    wait (rst_ni === 1'b1);
    while (byte_stream.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    drain_cycles = 0;
    while (pending_results.size() > 0 && drain_cycles < 5000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() > 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      errors++;
    end
    $display("Covered %0d frames, %0d bytes, %0d results checked, %0d input stall cycles.",
             frames_built, bytes_sent, results_seen, input_stalls);
    $display("Frame end status counts: ok %0d, truncated %0d, overrun %0d.",
             status_seen[0], status_seen[1], status_seen[2]);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ------------------------------------------------------------------- driver

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      send_gap      = 0;
      sender_burst  = 1'b0;
      clear_parse_state();
    end else begin
      offer_next = 1'b1;
      if (s_axis_tvalid) begin
        if (s_axis_tready) begin
          predict_parse(s_axis_tdata, s_axis_tlast);
          bytes_sent++;
        end else begin
          input_stalls++;
          offer_next = 1'b0;
        end
      end
      if (offer_next) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (byte_stream.size() > 0 &&
                     !(byte_stream[0].drain && pending_results.size() > 0)) begin
          nxt = byte_stream.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt.data;
          s_axis_tlast  <= nxt.fin;
          send_gap = sender_burst ? 0 : $urandom_range(0, 13);
          if ($urandom_range(0, 39) == 0) sender_burst = !sender_burst;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------ monitor

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_wait  = 0;
      hold_left  = 0;
      recv_burst = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind = kind_e'(m_axis_tuser);
        got.f    = m_axis_tdata;
        if (pending_results.size() == 0) begin
          $error("unexpected result transaction, kind %0d", got.kind);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(got.kind));
          check_field("frame_id", 32'(want.f.frame_id), 32'(got.f.frame_id));
          check_field("service", 32'(want.f.service), 32'(got.f.service));
          check_field("msg_type", 32'(want.f.msg_type), 32'(got.f.msg_type));
          check_field("xid", want.f.xid, got.f.xid);
          check_field("delay", 32'(want.f.delay), 32'(got.f.delay));
          check_field("data_length", 32'(want.f.data_length), 32'(got.f.data_length));
          check_field("option", 32'(want.f.option), 32'(got.f.option));
          check_field("suboption", 32'(want.f.suboption), 32'(got.f.suboption));
          check_field("block_length", 32'(want.f.block_length),
                      32'(got.f.block_length));
          check_field("block_byte", 32'(want.f.block_byte), 32'(got.f.block_byte));
          check_field("status", 32'(want.f.status), 32'(got.f.status));
          check_field("zero", 32'(want.f.zero), 32'(got.f.zero));
          if (want.kind == KIND_FRAME_END && want.f.status <= STATUS_OVERRUN) begin
            status_seen[want.f.status]++;
          end
        end
        results_seen++;
        // One long hold-off lets the output queue fill and back up the input.
        if (results_seen == HOLD_AT) hold_left = HOLD_CYCLES;
        recv_wait = recv_burst ? 0 : $urandom_range(0, 13);
        if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

endmodule
